// ===== rtl/ast_pkg.sv =====
// Shared types and codes for the allocation safety tracker.
package ast_pkg;

  localparam int unsigned ADDR_PORT_W = 64;
  localparam int unsigned SIZE_W      = 64;

  localparam logic [3:0] OP_ALLOC_REQ    = 4'd0;
  localparam logic [3:0] OP_ALLOC_RET    = 4'd1;
  localparam logic [3:0] OP_FREE         = 4'd2;
  localparam logic [3:0] OP_REALLOC_FREE = 4'd3;
  localparam logic [3:0] OP_REALLOC_RET  = 4'd4;
  localparam logic [3:0] OP_ACCESS       = 4'd5;
  localparam logic [3:0] OP_START        = 4'd6;
  localparam logic [3:0] OP_STOP         = 4'd7;
  localparam logic [3:0] OP_LEAK_SCAN    = 4'd8;

  localparam logic [3:0] ST_OK              = 4'd0;
  localparam logic [3:0] ST_DOUBLE_FREE     = 4'd1;
  localparam logic [3:0] ST_INVALID_FREE    = 4'd2;
  localparam logic [3:0] ST_USE_AFTER_FREE  = 4'd3;
  localparam logic [3:0] ST_REALLOC_MISSING = 4'd4;
  localparam logic [3:0] ST_NULL_RETURN     = 4'd5;
  localparam logic [3:0] ST_LIVE_REALLOC    = 4'd6;
  localparam logic [3:0] ST_LEAK            = 4'd7;
  localparam logic [3:0] ST_TABLE_FULL      = 4'd8;
  localparam logic [3:0] ST_IGNORED         = 4'd9;

  // operand count of an access that gets checked
  localparam logic [2:0] OPC_CHECKED = 3'd2;

  typedef struct packed {
    logic [3:0]             operation;
    logic [ADDR_PORT_W-1:0] address;
    logic [SIZE_W-1:0]      size;
    logic [2:0]             operand_count;
    logic                   in_main_image;
  } ast_in_t;

  typedef struct packed {
    logic [3:0]             status;
    logic [ADDR_PORT_W-1:0] report_address;
    logic                   last;
  } ast_out_t;

  typedef struct packed {
    logic set_freed;
    logic clr_freed;
    logic append;
    logic scan_load;
    logic scan_adv;
  } ast_cell_cmd_t;

  typedef struct packed {
    logic valid;
    logic freed;
    logic match;
    logic hit;
    logic tok;
  } ast_cell_stat_t;

endpackage

// ===== rtl/allocation_safety_tracker.sv =====
// Top level of the allocation safety tracker: control, cell chain and output register.
//
//   channel | direction | handshake            | payload
//   in_     | input     | in_valid / in_ready  | in_data  (ast_in_t)
//   out_    | output    | out_valid / out_ready| out_data (ast_out_t)
//
// An item is registered first; then every cell compares the address at once and the single
// result is loaded into the output register.
// A leak scan walks a token down the chain one cell a cycle while no leak result waits on
// out_ready; no new item is accepted until the scan closes.
// Reset (rst_n, synchronous) empties the table at once; no clearing pass.
// A full output register stalls only the step that produces a result.
module allocation_safety_tracker #(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned ADDR_WIDTH  = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ast_pkg::ast_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output ast_pkg::ast_out_t out_data
);
  import ast_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_SCAN = 3'b100
  } state_t;

  state_t                state_r, state_nxt;
  ast_in_t               item_r;
  logic                  tracing_r, tracing_nxt;
  logic [SIZE_W-1:0]     pend_r, pend_nxt;
  logic                  held_r, held_nxt;
  logic [ADDR_WIDTH-1:0] held_addr_r, held_addr_nxt;
  logic                  out_valid_r, out_valid_nxt;
  ast_out_t              out_data_r, out_data_nxt;

  ast_cell_cmd_t         cmd;
  ast_cell_stat_t        stat [TABLE_DEPTH];
  logic [ADDR_WIDTH-1:0] base [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] valid_v, freed_v, match_v, hit_v, tok_v;

  logic [ADDR_WIDTH-1:0] addr;
  logic [ADDR_PORT_W-1:0] addr_ext;
  logic [ADDR_WIDTH-1:0] base_sel;
  logic                  any_m, m_freed, m_live, full, any_hit;
  logic                  tok_valid, tok_live;
  logic                  out_free;
  logic                  is_scan;
  logic [3:0]            st;
  logic [ADDR_PORT_W-1:0] ra;
  ast_cell_cmd_t         op_cmd;

  assign addr     = item_r.address[ADDR_WIDTH-1:0];
  assign addr_ext = ADDR_PORT_W'(addr);
  assign out_free = !out_valid_r || out_ready;
  assign is_scan  = (item_r.operation == OP_LEAK_SCAN);

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    ast_cell #(
      .ADDR_WIDTH(ADDR_WIDTH)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .head       ((i == 0) ? 1'b1 : 1'b0),
      .prev_valid ((i == 0) ? 1'b1 : valid_v[(i == 0) ? 0 : i - 1]),
      .tok_in     ((i == 0) ? 1'b0 : tok_v[(i == 0) ? 0 : i - 1]),
      .addr       (addr),
      .size_wr    (pend_r),
      .stat       (stat[i]),
      .base       (base[i])
    );
    assign valid_v[i] = stat[i].valid;
    assign freed_v[i] = stat[i].freed;
    assign match_v[i] = stat[i].match;
    assign hit_v[i]   = stat[i].hit;
    assign tok_v[i]   = stat[i].tok;
  end

  assign any_m     = |match_v;
  assign m_freed   = |(match_v & freed_v);
  assign m_live    = |(match_v & ~freed_v);
  assign full      = valid_v[TABLE_DEPTH-1];
  assign any_hit   = |hit_v;
  assign tok_valid = |(tok_v & valid_v);
  assign tok_live  = |(tok_v & valid_v & ~freed_v);

  always_comb begin
    base_sel = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (tok_v[i]) begin
        base_sel = base_sel | base[i];
      end
    end
  end

  // decode of one item against the table
  always_comb begin
    st          = ST_OK;
    ra          = addr_ext;
    op_cmd      = '0;
    tracing_nxt = tracing_r;
    pend_nxt    = pend_r;
    if (item_r.operation <= OP_REALLOC_RET && !tracing_r) begin
      st = ST_IGNORED;
      if (item_r.operation == OP_ALLOC_REQ) begin
        ra = '0;
      end
    end else begin
      unique case (item_r.operation)
        OP_ALLOC_REQ: begin
          pend_nxt = item_r.size;
          ra       = '0;
        end
        OP_ALLOC_RET: begin
          if (addr == '0) begin
            st = ST_NULL_RETURN;
          end else if (any_m) begin
            if (m_freed) begin
              op_cmd.clr_freed = 1'b1;
            end else begin
              st = ST_LIVE_REALLOC;
            end
          end else if (full) begin
            st = ST_TABLE_FULL;
          end else begin
            op_cmd.append = 1'b1;
          end
        end
        OP_FREE: begin
          if (!any_m) begin
            st = ST_INVALID_FREE;
          end else if (m_freed) begin
            st = ST_DOUBLE_FREE;
          end else begin
            op_cmd.set_freed = 1'b1;
          end
        end
        OP_REALLOC_FREE: begin
          if (!any_m) begin
            st = ST_REALLOC_MISSING;
          end else begin
            op_cmd.set_freed = 1'b1;
          end
        end
        OP_REALLOC_RET: begin
          if (addr != '0) begin
            op_cmd.clr_freed = 1'b1;
            if (m_live) begin
              st = ST_LIVE_REALLOC;
            end
          end
        end
        OP_ACCESS: begin
          if (item_r.operand_count != OPC_CHECKED || !item_r.in_main_image) begin
            st = ST_IGNORED;
          end else if (any_hit) begin
            st = ST_USE_AFTER_FREE;
          end
        end
        OP_START: begin
          tracing_nxt = 1'b1;
          ra          = '0;
        end
        OP_STOP: begin
          tracing_nxt = 1'b0;
          ra          = '0;
        end
        OP_LEAK_SCAN: begin
          op_cmd.scan_load = 1'b1;
        end
        default: begin
          st = ST_IGNORED;
        end
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    held_nxt      = held_r;
    held_addr_nxt = held_addr_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (is_scan) begin
          cmd.scan_load = 1'b1;
          held_nxt      = 1'b0;
          state_nxt     = S_SCAN;
        end else if (out_free) begin
          cmd                         = op_cmd;
          out_valid_nxt               = 1'b1;
          out_data_nxt.status         = st;
          out_data_nxt.report_address = ra;
          out_data_nxt.last           = 1'b1;
          state_nxt                   = S_IDLE;
        end
      end
      S_SCAN: begin
        if (!tok_valid) begin
          // token ran past the filled part: close the scan
          if (out_free) begin
            out_valid_nxt               = 1'b1;
            out_data_nxt.status         = held_r ? ST_LEAK : ST_OK;
            out_data_nxt.report_address = held_r ? ADDR_PORT_W'(held_addr_r) : '0;
            out_data_nxt.last           = 1'b1;
            state_nxt                   = S_IDLE;
          end
        end else if (tok_live && held_r) begin
          if (out_free) begin
            out_valid_nxt               = 1'b1;
            out_data_nxt.status         = ST_LEAK;
            out_data_nxt.report_address = ADDR_PORT_W'(held_addr_r);
            out_data_nxt.last           = 1'b0;
            held_addr_nxt               = base_sel;
            cmd.scan_adv                = 1'b1;
          end
        end else begin
          if (tok_live) begin
            held_nxt      = 1'b1;
            held_addr_nxt = base_sel;
          end
          cmd.scan_adv = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tracing_r   <= 1'b0;
      pend_r      <= '0;
      held_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
      if (state_r == S_EXEC && !is_scan && out_free) begin
        tracing_r <= tracing_nxt;
        pend_r    <= pend_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
    held_addr_r <= held_addr_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/ast_cell.sv =====
// One allocation record of the tracker chain, with its match and range test.
module ast_cell #(
  parameter int unsigned ADDR_WIDTH = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ast_pkg::ast_cell_cmd_t     cmd,
  input  logic                       head,
  input  logic                       prev_valid,
  input  logic                       tok_in,
  input  logic [ADDR_WIDTH-1:0]      addr,
  input  logic [ast_pkg::SIZE_W-1:0] size_wr,
  output ast_pkg::ast_cell_stat_t    stat,
  output logic [ADDR_WIDTH-1:0]      base
);
  import ast_pkg::*;

  logic                  valid_r, valid_nxt;
  logic                  freed_r, freed_nxt;
  logic                  tok_r, tok_nxt;
  logic [ADDR_WIDTH-1:0] base_r, base_nxt;
  logic [SIZE_W-1:0]     size_r, size_nxt;
  logic [ADDR_WIDTH-1:0] diff;
  logic                  match;
  logic                  in_range;
  logic                  take;

  assign match    = valid_r && (base_r == addr);
  assign diff     = addr - base_r;
  assign in_range = (addr >= base_r) && (SIZE_W'(diff) < size_r);
  // the first empty cell behind the filled part takes the new record
  assign take     = cmd.append && prev_valid && !valid_r;

  always_comb begin
    valid_nxt = valid_r;
    freed_nxt = freed_r;
    base_nxt  = base_r;
    size_nxt  = size_r;
    tok_nxt   = tok_r;
    if (take) begin
      valid_nxt = 1'b1;
      freed_nxt = 1'b0;
      base_nxt  = addr;
      size_nxt  = size_wr;
    end else if (cmd.set_freed && match) begin
      freed_nxt = 1'b1;
    end else if (cmd.clr_freed && match) begin
      freed_nxt = 1'b0;
    end
    if (cmd.scan_load) begin
      tok_nxt = head;
    end else if (cmd.scan_adv) begin
      tok_nxt = tok_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      tok_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      tok_r   <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    freed_r <= freed_nxt;
    base_r  <= base_nxt;
    size_r  <= size_nxt;
  end

  assign stat.valid = valid_r;
  assign stat.freed = freed_r;
  assign stat.match = match;
  assign stat.hit   = valid_r && freed_r && in_range;
  assign stat.tok   = tok_r;
  assign base       = base_r;

endmodule

// ===== rtl/ast_checker.sv =====
// Port-level checks for the allocation safety tracker and their bind.
module ast_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input ast_pkg::ast_in_t  in_data,
  input logic              out_valid,
  input logic              out_ready,
  input ast_pkg::ast_out_t out_data
);
  import ast_pkg::*;

  logic unused_in;
  assign unused_in = ^in_data;

  a_reset_clean: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && in_ready))
    else $error("outputs not idle after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item taken while one is in work");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status <= ST_IGNORED))
    else $error("status code out of range");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != ST_LEAK) |-> out_data.last)
    else $error("non-leak result without last");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

endmodule

bind allocation_safety_tracker ast_checker u_ast_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== verif/tb_allocation_safety_tracker.sv =====
// Self-checking testbench for the allocation safety tracker: directed table, then random traffic.
`timescale 1ns / 1ps

module tb_allocation_safety_tracker;
  import ast_pkg::*;

  localparam int unsigned TRACK_DEPTH = 64;
  localparam int unsigned ADDR_BITS   = 64;
  localparam logic [63:0] ADDR_MASK   = {64{1'b1}} >> (64 - ADDR_BITS);
  localparam int RANDOM_ITEMS  = 100;
  localparam int FILL_ITEMS    = 68;
  localparam int STALL_LIMIT   = 2000;
  localparam int DRAIN_CYCLES  = 80;

  typedef struct packed {
    logic [3:0]  op;
    logic [63:0] addr;
    logic [63:0] size;
    logic [2:0]  opc;
    logic        main_img;
    logic        typed_exp;
    logic [3:0]  st;
    logic [63:0] ra;
  } dir_row_t;

  // rows with typed_exp set carry their own expected result; the rest use the predictor
  localparam dir_row_t DIRECTED [29] = '{
    '{OP_ALLOC_RET, 64'h1000, 64'h0, OPC_CHECKED, 1'b1, 1'b1, ST_IGNORED, 64'h1000},
    '{OP_ALLOC_REQ, 64'h0, 64'h40, 3'd0, 1'b0, 1'b1, ST_IGNORED, 64'h0},
    '{OP_LEAK_SCAN, 64'h0, 64'h0, 3'd0, 1'b0, 1'b1, ST_OK, 64'h0},
    '{OP_ACCESS, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, OPC_CHECKED, 1'b1, 1'b1, ST_OK,
      64'hFFFF_FFFF_FFFF_FFFF},
    '{OP_ACCESS, 64'h1000, 64'h0, 3'd7, 1'b1, 1'b1, ST_IGNORED, 64'h1000},
    '{OP_ACCESS, 64'h1000, 64'h0, OPC_CHECKED, 1'b0, 1'b1, ST_IGNORED, 64'h1000},
    '{4'hF, 64'hA5A5_5A5A_A5A5_5A5A, 64'h0, 3'd0, 1'b0, 1'b1, ST_IGNORED,
      64'hA5A5_5A5A_A5A5_5A5A},
    '{OP_START, 64'h0, 64'h0, 3'd0, 1'b0, 1'b1, ST_OK, 64'h0},
    '{OP_ALLOC_REQ, 64'h0, 64'h100, 3'd0, 1'b0, 1'b1, ST_OK, 64'h0},
    '{OP_ALLOC_RET, 64'h0, 64'h0, 3'd0, 1'b0, 1'b1, ST_NULL_RETURN, 64'h0},
    '{OP_ALLOC_RET, 64'h1000, 64'h0, 3'd0, 1'b0, 1'b1, ST_OK, 64'h1000},
    '{OP_ALLOC_RET, 64'h1000, 64'h0, 3'd0, 1'b0, 1'b1, ST_LIVE_REALLOC, 64'h1000},
    '{OP_FREE, 64'h2000, 64'h0, 3'd0, 1'b0, 1'b1, ST_INVALID_FREE, 64'h2000},
    '{OP_FREE, 64'h1000, 64'h0, 3'd0, 1'b0, 1'b1, ST_OK, 64'h1000},
    '{OP_FREE, 64'h1000, 64'h0, 3'd0, 1'b0, 1'b1, ST_DOUBLE_FREE, 64'h1000},
    '{OP_ACCESS, 64'h10FF, 64'h0, OPC_CHECKED, 1'b1, 1'b0, ST_OK, 64'h0},
    '{OP_ACCESS, 64'h1100, 64'h0, OPC_CHECKED, 1'b1, 1'b0, ST_OK, 64'h0},
    '{OP_ALLOC_REQ, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 3'd0, 1'b0, 1'b0, ST_OK, 64'h0},
    '{OP_ALLOC_RET, 64'hFFFF_FFFF_FFFF_FF00, 64'h0, 3'd0, 1'b0, 1'b0, ST_OK, 64'h0},
    '{OP_REALLOC_FREE, 64'h3000, 64'h0, 3'd0, 1'b0, 1'b1, ST_REALLOC_MISSING, 64'h3000},
    '{OP_REALLOC_FREE, 64'hFFFF_FFFF_FFFF_FF00, 64'h0, 3'd0, 1'b0, 1'b0, ST_OK, 64'h0},
    '{OP_ACCESS, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, OPC_CHECKED, 1'b1, 1'b0, ST_OK, 64'h0},
    '{OP_REALLOC_RET, 64'h0, 64'h0, 3'd0, 1'b0, 1'b1, ST_OK, 64'h0},
    '{OP_REALLOC_RET, 64'hFFFF_FFFF_FFFF_FF00, 64'h0, 3'd0, 1'b0, 1'b0, ST_OK, 64'h0},
    '{OP_REALLOC_RET, 64'hFFFF_FFFF_FFFF_FF00, 64'h0, 3'd0, 1'b0, 1'b0, ST_OK, 64'h0},
    '{OP_ALLOC_RET, 64'h1000, 64'h0, 3'd0, 1'b0, 1'b0, ST_OK, 64'h0},
    '{OP_LEAK_SCAN, 64'h0, 64'h0, 3'd0, 1'b0, 1'b0, ST_OK, 64'h0},
    '{OP_STOP, 64'h0, 64'h0, 3'd0, 1'b0, 1'b1, ST_OK, 64'h0},
    '{OP_FREE, 64'h1000, 64'h0, 3'd0, 1'b0, 1'b1, ST_IGNORED, 64'h1000}
  };

  logic     clk;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  ast_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  ast_out_t out_data;

  // shadow of the allocation table
  logic [63:0] base_tab [TRACK_DEPTH];
  logic [63:0] size_tab [TRACK_DEPTH];
  logic        freed_tab [TRACK_DEPTH];
  int          tab_used    = 0;
  logic [63:0] pending_sz  = '0;
  logic        trace_on    = 1'b0;

  ast_out_t step_results[$];
  ast_out_t expected_reports[$];
  int       fail_count   = 0;
  int       quiet_cycles = 0;
  bit       calm         = 1'b0;

  allocation_safety_tracker #(
    .TABLE_DEPTH(TRACK_DEPTH),
    .ADDR_WIDTH (ADDR_BITS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] pick_addr(input int known_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (tab_used > 0 && roll < known_pct) return base_tab[$urandom_range(0, tab_used - 1)];
    if (roll >= 95) return '0;
    return rand64();
  endfunction

  // Apply one event to the shadow table and leave its results in step_results.
  function automatic logic [3:0] track_event(input ast_in_t it);
    logic [63:0] a;
    ast_out_t    res;
    int          hit;
    bit          scan;
    a = it.address & ADDR_MASK;
    res.status = ST_OK;
    res.report_address = a;
    res.last = 1'b1;
    hit = -1;
    scan = 1'b0;
    step_results.delete();
    for (int i = 0; i < tab_used; i++)
      if (hit < 0 && base_tab[i] == a) hit = i;

    if (it.operation <= OP_REALLOC_RET && !trace_on) begin
      res.status = ST_IGNORED;
      if (it.operation == OP_ALLOC_REQ) res.report_address = '0;
    end else begin
      case (it.operation)
        OP_ALLOC_REQ: begin
          pending_sz = it.size;
          res.report_address = '0;
        end
        OP_ALLOC_RET: begin
          if (a == '0) res.status = ST_NULL_RETURN;
          else if (hit >= 0) begin
            // reuse keeps the old size
            if (freed_tab[hit]) freed_tab[hit] = 1'b0;
            else res.status = ST_LIVE_REALLOC;
          end else if (tab_used >= TRACK_DEPTH) res.status = ST_TABLE_FULL;
          else begin
            base_tab[tab_used] = a;
            size_tab[tab_used] = pending_sz;
            freed_tab[tab_used] = 1'b0;
            tab_used++;
          end
        end
        OP_FREE: begin
          if (hit < 0) res.status = ST_INVALID_FREE;
          else if (freed_tab[hit]) res.status = ST_DOUBLE_FREE;
          else freed_tab[hit] = 1'b1;
        end
        OP_REALLOC_FREE: begin
          if (hit < 0) res.status = ST_REALLOC_MISSING;
          else freed_tab[hit] = 1'b1;
        end
        OP_REALLOC_RET: begin
          if (a != '0)
            for (int i = 0; i < tab_used; i++)
              if (base_tab[i] == a) begin
                if (freed_tab[i]) freed_tab[i] = 1'b0;
                else res.status = ST_LIVE_REALLOC;
              end
        end
        OP_ACCESS: begin
          if (it.operand_count != OPC_CHECKED || !it.in_main_image) res.status = ST_IGNORED;
          else
            for (int i = 0; i < tab_used; i++)
              if (freed_tab[i] && a >= base_tab[i] && (a - base_tab[i]) < size_tab[i])
                res.status = ST_USE_AFTER_FREE;
        end
        OP_START: begin
          trace_on = 1'b1;
          res.report_address = '0;
        end
        OP_STOP: begin
          trace_on = 1'b0;
          res.report_address = '0;
        end
        OP_LEAK_SCAN: begin
          scan = 1'b1;
          for (int i = 0; i < tab_used; i++)
            if (!freed_tab[i]) begin
              res.status = ST_LEAK;
              res.report_address = base_tab[i];
              res.last = 1'b0;
              step_results.insert(step_results.size(), res);
            end
          if (step_results.size() == 0) begin
            res.status = ST_OK;
            res.report_address = '0;
            res.last = 1'b1;
            step_results.insert(step_results.size(), res);
          end else begin
            res = step_results.pop_back();
            res.last = 1'b1;
            step_results.insert(step_results.size(), res);
          end
        end
        default: res.status = ST_IGNORED;
      endcase
    end
    if (!scan) step_results.insert(step_results.size(), res);
    return step_results[0].status;
  endfunction

  // Record the expected results, then hold the item on the input until the transfer.
  task automatic issue(input ast_in_t it, input bit typed_exp, input ast_out_t want,
                       output bit counted);
    logic [3:0] first_st;
    first_st = track_event(it);
    counted = (first_st != ST_IGNORED);
    if (typed_exp) expected_reports.insert(expected_reports.size(), want);
    else foreach (step_results[i])
      expected_reports.insert(expected_reports.size(), step_results[i]);
    while (!calm && $urandom_range(0, 99) < 32) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  initial begin
    ast_in_t     it;
    ast_out_t    want;
    bit          counted;
    bit          fill_done;
    int          tracked_items;
    int          roll;
    int          idx;
    logic [63:0] span;

    fill_done = 1'b0;
    tracked_items = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < 29; r++) begin
      it.operation     = DIRECTED[r].op;
      it.address       = DIRECTED[r].addr;
      it.size          = DIRECTED[r].size;
      it.operand_count = DIRECTED[r].opc;
      it.in_main_image = DIRECTED[r].main_img;
      want.status         = DIRECTED[r].st;
      want.report_address = DIRECTED[r].ra;
      want.last           = 1'b1;
      issue(it, DIRECTED[r].typed_exp, want, counted);
    end

    // hold off until the table has answered everything
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_reports.size() != 0);

    want = '0;
    while (tracked_items < RANDOM_ITEMS) begin
      it.address       = rand64();
      it.size          = rand64();
      it.operand_count = $urandom_range(0, 7);
      it.in_main_image = $urandom_range(0, 1);
      if (!fill_done && tracked_items >= 30) begin
        // fill the table past its depth with both sides running flat out
        in_valid <= 1'b0;
        do @(posedge clk); while (expected_reports.size() != 0);
        calm = 1'b1;
        it.operation = OP_START;
        issue(it, 1'b0, want, counted);
        tracked_items += counted;
        for (int k = 0; k < FILL_ITEMS; k++) begin
          it.operation = OP_ALLOC_RET;
          it.address   = rand64();
          issue(it, 1'b0, want, counted);
          tracked_items += counted;
        end
        calm = 1'b0;
        fill_done = 1'b1;
      end else begin
        roll = $urandom_range(0, 99);
        if (!trace_on && roll < 70) it.operation = OP_START;
        else if (roll < 12) begin
          it.operation = OP_ALLOC_REQ;
          idx = $urandom_range(0, 99);
          if (idx < 70) it.size = 64'($urandom_range(1, 4096));
          else if (idx < 85) it.size = '0;
        end else if (roll < 30) begin
          it.operation = OP_ALLOC_RET;
          it.address   = pick_addr(40);
        end else if (roll < 45) begin
          it.operation = OP_FREE;
          it.address   = pick_addr(75);
        end else if (roll < 55) begin
          it.operation = OP_REALLOC_FREE;
          it.address   = pick_addr(75);
        end else if (roll < 63) begin
          it.operation = OP_REALLOC_RET;
          it.address   = pick_addr(70);
        end else if (roll < 85) begin
          it.operation = OP_ACCESS;
          if ($urandom_range(0, 9) < 8) it.operand_count = OPC_CHECKED;
          if ($urandom_range(0, 9) < 9) it.in_main_image = 1'b1;
          // aim near a recorded chunk, on both sides of its edges
          if (tab_used > 0 && $urandom_range(0, 99) < 75) begin
            idx  = $urandom_range(0, tab_used - 1);
            span = size_tab[idx] + 64'd16;
            if ($urandom_range(0, 4) == 0)
              it.address = base_tab[idx] - 64'($urandom_range(1, 16));
            else
              it.address = base_tab[idx] + ((span == '0) ? rand64() : rand64() % span);
          end
        end else if (roll < 89) it.operation = OP_LEAK_SCAN;
        else if (roll < 93) it.operation = trace_on ? OP_STOP : OP_START;
        else if (roll < 96) it.operation = 4'($urandom_range(9, 15));
        else it.operation = OP_START;
        issue(it, 1'b0, want, counted);
        tracked_items += counted;
      end
    end

    in_valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  // result side: random backpressure and in-order check
  always @(posedge clk) begin
    ast_out_t want;
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= calm || ($urandom_range(0, 99) >= 32);
    if (rst_n && out_valid && out_ready) begin
      if (expected_reports.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result: status %0d addr %h last %b",
                   out_data.status, out_data.report_address, out_data.last);
      end else begin
        want = expected_reports.pop_front();
        if (out_data.status !== want.status ||
            out_data.report_address !== want.report_address ||
            out_data.last !== want.last) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: exp st %0d addr %h last %b, got st %0d addr %h last %b",
                     want.status, want.report_address, want.last,
                     out_data.status, out_data.report_address, out_data.last);
        end
      end
    end
  end

  // count cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

endmodule
